// ===== src/gbr_pkg.sv =====
// shared types, constants and state codes for the graph bisection refiner
`default_nettype none
package gbr_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int CUT_BITS         = 26;
  localparam logic [CUT_BITS-1:0] CUT_MAX = 26'h3FFFFFF;
  localparam logic [7:0] MAX_PASSES_RST = 8'd10;

  typedef enum logic [1:0] {
    ACT_EDGE = 2'd0,
    ACT_SIDE = 2'd1,
    ACT_RUN  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [4:0]  vertex_u;
    logic [4:0]  vertex_v;
    logic [15:0] edge_cost;
    logic        side_in;
  } in_t;

  typedef struct packed {
    logic [4:0]          vertex_index;
    logic                side_out;
    logic [CUT_BITS-1:0] cut_weight;
    logic                last;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EDGE2, ST_PCHK, ST_COST, ST_SSTART, ST_SA, ST_SAW,
    ST_SB, ST_LOCK, ST_ADJ, ST_ENDP, ST_APPLY, ST_CUT, ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== src/gbr_adj_mem.sv =====
// adjacency weight memory with a clearing sweep after reset
`default_nettype none
module gbr_adj_mem #(
  parameter int VW          = 5,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [2*VW-1:0]        wr_addr,
  input  wire logic [WEIGHT_BITS-1:0] wr_data,
  input  wire logic [2*VW-1:0]        rd_addr,
  output logic      [WEIGHT_BITS-1:0] rd_data,
  output logic                        clear_done
);
  localparam int AW = 2 * VW;

  logic [WEIGHT_BITS-1:0] mem [2**AW];
  logic [AW:0]            clr_cnt_r, clr_cnt_nxt;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [WEIGHT_BITS-1:0] wd;

  function automatic logic [AW:0] clearing_step(input logic [AW:0] c);
    clearing_step = c[AW] ? c : c + 1'b1;
  endfunction

  assign clear_done = clr_cnt_r[AW];

  always_comb begin
    clr_cnt_nxt = clearing_step(clr_cnt_r);
    if (!clr_cnt_r[AW]) begin
      we = 1'b1;
      wa = clr_cnt_r[AW-1:0];
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/graph_bisection_refiner.sv =====
// top level of the kernighan-lin graph bisection refiner
//
//  port group   dir  handshake                 payload
//  in_          in   start high, busy low      in_data  (gbr_pkg::in_t)
//  out_         out  out_valid, one cycle      out_data (gbr_pkg::out_t)
//  cfg_         in   cfg_we                    cfg_wdata (max_passes)
//
// after reset every adjacency memory entry is swept to zero, one entry a cycle,
//   and busy stays high meanwhile
// edge load: both mirrored entries go in turn through the single write port
// side load: one side bit; action 3 and out-of-range endpoints: no effect
// run: each pass builds the costs from all n*n entries, then for each swap
//   searches the free pairs and updates costs from both swapped rows, then
//   applies the best prefix; then cut total over n*n entries, n results
// the run time is set by the single read port of the adjacency memory
// results leave one per cycle and cannot be held off by the receiver
`default_nettype none
module graph_bisection_refiner #(
  parameter int MAX_VERTICES = gbr_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = gbr_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire gbr_pkg::in_t in_data,
  output logic              out_valid,
  output gbr_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata
);
  import gbr_pkg::*;

  // widths: vertex index, cost, gain, running sum, cut accumulator
  localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW   = 2 * VW;
  localparam int DW   = WEIGHT_BITS + VW + 4;
  localparam int GW   = DW + 2;
  localparam int SW   = GW + VW;
  localparam int CW   = WEIGHT_BITS + 2 * VW;
  localparam int LOGD = MAX_VERTICES / 2 + 1;
  localparam int LIW  = $clog2(LOGD);

  state_t                  state_r, state_nxt;
  logic [VW:0]             n_r, n_nxt;
  logic [MAX_VERTICES-1:0] side_r, side_nxt;
  logic [MAX_VERTICES-1:0] locked_r, locked_nxt;
  logic [7:0]              max_passes_r, max_passes_nxt;
  logic [7:0]              pass_cnt_r, pass_cnt_nxt;
  logic [VW:0]             i_r, i_nxt, j_r, j_nxt;
  logic                    p_vld_r, p_vld_nxt, p_last_r, p_last_nxt;
  logic [VW-1:0]           p_i_r, p_i_nxt, p_j_r, p_j_nxt;
  logic signed [DW-1:0]    acc_r, acc_nxt, da_r, da_nxt;
  logic                    found_r, found_nxt;
  logic signed [GW-1:0]    best_r, best_nxt;
  logic [VW-1:0]           ba_r, ba_nxt, bb_r, bb_nxt;
  logic [LIW-1:0]          logged_r, logged_nxt, best_k_r, best_k_nxt, k_r, k_nxt;
  logic signed [SW-1:0]    sum_r, sum_nxt, best_sum_r, best_sum_nxt;
  logic                    sel_r, sel_nxt;
  logic [CW-1:0]           cut_r, cut_nxt;
  logic [VW-1:0]           e_u_r, e_u_nxt, e_v_r, e_v_nxt;
  logic [WEIGHT_BITS-1:0]  e_w_r, e_w_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_data_r, out_data_nxt;

  // swap log and cost memory
  logic [VW-1:0]        swap_a_r [LOGD];
  logic [VW-1:0]        swap_b_r [LOGD];
  logic signed [DW-1:0] d_mem [MAX_VERTICES];
  logic signed [DW-1:0] d_q;
  logic                 d_we, log_we;
  logic [VW-1:0]        d_waddr, d_raddr;
  logic signed [DW-1:0] d_wdata;

  // adjacency memory access
  logic                   adj_we, clear_done;
  logic [AW-1:0]          adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_wdata, adj_q;

  // decoded input item
  logic [6:0]             u7, v7;
  logic [VW-1:0]          uv, vv;
  logic                   u_ok, v_ok;
  logic [31:0]            ec32;
  logic [WEIGHT_BITS-1:0] w_in;

  // datapath terms
  logic signed [DW-1:0] wd;
  logic signed [GW-1:0] wg, gain;
  logic signed [SW-1:0] sum_new;
  logic [VW-1:0]        s_idx;
  logic [63:0]          cut_ext;
  logic [CUT_BITS-1:0]  cut_sat;

  gbr_adj_mem #(
    .VW          (VW),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_adj (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (adj_we),
    .wr_addr    (adj_waddr),
    .wr_data    (adj_wdata),
    .rd_addr    (adj_raddr),
    .rd_data    (adj_q),
    .clear_done (clear_done)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign u7   = 7'(in_data.vertex_u);
  assign v7   = 7'(in_data.vertex_v);
  assign u_ok = (u7 < 7'(MAX_VERTICES));
  assign v_ok = (v7 < 7'(MAX_VERTICES));
  assign uv   = u7[VW-1:0];
  assign vv   = v7[VW-1:0];
  assign ec32 = {16'b0, in_data.edge_cost};
  assign w_in = ec32[WEIGHT_BITS-1:0];

  assign wd      = DW'($signed({1'b0, adj_q}));
  assign wg      = GW'($signed({1'b0, adj_q}));
  assign gain    = GW'(da_r) + GW'(d_q) - (wg <<< 1);
  assign sum_new = sum_r + SW'(best_r);
  assign s_idx   = sel_r ? bb_r : ba_r;
  assign cut_ext = 64'(cut_r);
  assign cut_sat = (cut_ext > 64'(CUT_MAX)) ? CUT_MAX : cut_ext[CUT_BITS-1:0];

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    side_nxt       = side_r;
    locked_nxt     = locked_r;
    max_passes_nxt = cfg_we ? cfg_wdata : max_passes_r;
    pass_cnt_nxt   = pass_cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    p_vld_nxt      = 1'b0;
    p_last_nxt     = 1'b0;
    p_i_nxt        = p_i_r;
    p_j_nxt        = p_j_r;
    acc_nxt        = acc_r;
    da_nxt         = da_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    ba_nxt         = ba_r;
    bb_nxt         = bb_r;
    logged_nxt     = logged_r;
    best_k_nxt     = best_k_r;
    k_nxt          = k_r;
    sum_nxt        = sum_r;
    best_sum_nxt   = best_sum_r;
    sel_nxt        = sel_r;
    cut_nxt        = cut_r;
    e_u_nxt        = e_u_r;
    e_v_nxt        = e_v_r;
    e_w_nxt        = e_w_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    adj_we         = 1'b0;
    adj_waddr      = {uv, vv};
    adj_wdata      = w_in;
    adj_raddr      = {i_r[VW-1:0], j_r[VW-1:0]};
    d_we           = 1'b0;
    d_waddr        = p_j_r;
    d_wdata        = '0;
    d_raddr        = j_r[VW-1:0];
    log_we         = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        if (clear_done) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          unique case (in_data.action)
            ACT_EDGE: begin
              if (u_ok && v_ok) begin
                // first mirrored entry now, the other one next cycle
                adj_we  = 1'b1;
                e_u_nxt = uv;
                e_v_nxt = vv;
                e_w_nxt = w_in;
                if (u7 + 7'd1 > 7'(n_r)) n_nxt = (VW+1)'(u7 + 7'd1);
                if (v7 + 7'd1 > 7'(n_r) && v7 > u7) n_nxt = (VW+1)'(v7 + 7'd1);
                state_nxt = ST_EDGE2;
              end
            end
            ACT_SIDE: begin
              if (u_ok) side_nxt[uv] = in_data.side_in;
            end
            ACT_RUN: begin
              pass_cnt_nxt = '0;
              state_nxt    = ST_PCHK;
            end
            default: ;
          endcase
        end
      end

      ST_EDGE2: begin
        adj_we    = 1'b1;
        adj_waddr = {e_v_r, e_u_r};
        adj_wdata = e_w_r;
        state_nxt = ST_IDLE;
      end

      ST_PCHK: begin
        i_nxt = '0;
        j_nxt = '0;
        if (pass_cnt_r < max_passes_r) begin
          locked_nxt = '0;
          logged_nxt = '0;
          sum_nxt    = '0;
          acc_nxt    = '0;
          state_nxt  = ST_COST;
        end else begin
          cut_nxt   = '0;
          state_nxt = ST_CUT;
        end
      end

      // external minus internal cost, one adjacency entry a cycle
      ST_COST: begin
        if (i_r < n_r) begin
          p_vld_nxt  = 1'b1;
          p_i_nxt    = i_r[VW-1:0];
          p_j_nxt    = j_r[VW-1:0];
          p_last_nxt = (j_r == n_r - 1'b1);
          if (j_r == n_r - 1'b1) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else if (!p_vld_r) begin
          state_nxt = ST_SSTART;
        end
        if (p_vld_r) begin
          if (p_i_r == p_j_r) begin
            acc_nxt = acc_r - (wd <<< 1);
          end else if (side_r[p_i_r] != side_r[p_j_r]) begin
            acc_nxt = acc_r + wd;
          end else begin
            acc_nxt = acc_r - wd;
          end
          if (p_last_r) begin
            d_we    = 1'b1;
            d_waddr = p_i_r;
            d_wdata = acc_nxt;
            acc_nxt = '0;
          end
        end
      end

      ST_SSTART: begin
        if (8'(logged_r) * 8'd2 < 8'(n_r)) begin
          found_nxt = 1'b0;
          i_nxt     = '0;
          state_nxt = ST_SA;
        end else begin
          state_nxt = ST_ENDP;
        end
      end

      // outer scan over free part-a vertices
      ST_SA: begin
        d_raddr = i_r[VW-1:0];
        if (i_r == n_r) begin
          state_nxt = found_r ? ST_LOCK : ST_ENDP;
        end else if (side_r[i_r[VW-1:0]] || locked_r[i_r[VW-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = ST_SAW;
        end
      end

      ST_SAW: begin
        da_nxt    = d_q;
        j_nxt     = '0;
        state_nxt = ST_SB;
      end

      // inner scan over free part-b vertices, first strict maximum wins
      ST_SB: begin
        if (j_r < n_r) begin
          if (side_r[j_r[VW-1:0]] && !locked_r[j_r[VW-1:0]]) begin
            p_vld_nxt = 1'b1;
            p_j_nxt   = j_r[VW-1:0];
          end
          j_nxt = j_r + 1'b1;
        end else if (!p_vld_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SA;
        end
        if (p_vld_r && (!found_r || gain > best_r)) begin
          found_nxt = 1'b1;
          best_nxt  = gain;
          ba_nxt    = i_r[VW-1:0];
          bb_nxt    = p_j_r;
        end
      end

      ST_LOCK: begin
        locked_nxt[ba_r] = 1'b1;
        locked_nxt[bb_r] = 1'b1;
        log_we           = 1'b1;
        sum_nxt          = sum_new;
        if (logged_r == '0 || sum_new > best_sum_r) begin
          best_sum_nxt = sum_new;
          best_k_nxt   = logged_r;
        end
        logged_nxt = logged_r + 1'b1;
        sel_nxt    = 1'b0;
        j_nxt      = '0;
        state_nxt  = ST_ADJ;
      end

      // cost update for the swapped pair, read-modify-write of the cost memory
      ST_ADJ: begin
        adj_raddr = {s_idx, j_r[VW-1:0]};
        if (j_r < n_r) begin
          p_vld_nxt = 1'b1;
          p_j_nxt   = j_r[VW-1:0];
          j_nxt     = j_r + 1'b1;
        end else if (!p_vld_r) begin
          j_nxt = '0;
          if (!sel_r) begin
            sel_nxt = 1'b1;
          end else begin
            state_nxt = ST_SSTART;
          end
        end
        if (p_vld_r) begin
          d_we    = 1'b1;
          d_waddr = p_j_r;
          if (side_r[p_j_r] != side_r[s_idx]) begin
            d_wdata = d_q - (wd <<< 1);
          end else begin
            d_wdata = d_q + (wd <<< 1);
          end
        end
      end

      ST_ENDP: begin
        if (logged_r == '0 || best_sum_r <= 0) begin
          i_nxt     = '0;
          j_nxt     = '0;
          cut_nxt   = '0;
          state_nxt = ST_CUT;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_APPLY;
        end
      end

      ST_APPLY: begin
        side_nxt[swap_a_r[k_r]] = 1'b1;
        side_nxt[swap_b_r[k_r]] = 1'b0;
        if (k_r == best_k_r) begin
          pass_cnt_nxt = pass_cnt_r + 1'b1;
          state_nxt    = ST_PCHK;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // total weight over crossing pairs above the diagonal
      ST_CUT: begin
        if (i_r < n_r) begin
          p_vld_nxt = 1'b1;
          p_i_nxt   = i_r[VW-1:0];
          p_j_nxt   = j_r[VW-1:0];
          if (j_r == n_r - 1'b1) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else if (!p_vld_r) begin
          i_nxt     = '0;
          state_nxt = ST_EMIT;
        end
        if (p_vld_r && p_j_r > p_i_r && side_r[p_i_r] != side_r[p_j_r]) begin
          cut_nxt = cut_r + CW'(adj_q);
        end
      end

      ST_EMIT: begin
        if (i_r < n_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.vertex_index = 5'(i_r);
          out_data_nxt.side_out     = side_r[i_r[VW-1:0]];
          out_data_nxt.cut_weight   = cut_sat;
          out_data_nxt.last         = (i_r == n_r - 1'b1);
          i_nxt                     = i_r + 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      n_r          <= '0;
      side_r       <= '0;
      locked_r     <= '0;
      max_passes_r <= MAX_PASSES_RST;
      pass_cnt_r   <= '0;
      i_r          <= '0;
      j_r          <= '0;
      p_vld_r      <= 1'b0;
      p_last_r     <= 1'b0;
      found_r      <= 1'b0;
      logged_r     <= '0;
      best_k_r     <= '0;
      k_r          <= '0;
      sel_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      side_r       <= side_nxt;
      locked_r     <= locked_nxt;
      max_passes_r <= max_passes_nxt;
      pass_cnt_r   <= pass_cnt_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      p_vld_r      <= p_vld_nxt;
      p_last_r     <= p_last_nxt;
      found_r      <= found_nxt;
      logged_r     <= logged_nxt;
      best_k_r     <= best_k_nxt;
      k_r          <= k_nxt;
      sel_r        <= sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_i_r      <= p_i_nxt;
    p_j_r      <= p_j_nxt;
    acc_r      <= acc_nxt;
    da_r       <= da_nxt;
    best_r     <= best_nxt;
    ba_r       <= ba_nxt;
    bb_r       <= bb_nxt;
    sum_r      <= sum_nxt;
    best_sum_r <= best_sum_nxt;
    cut_r      <= cut_nxt;
    e_u_r      <= e_u_nxt;
    e_v_r      <= e_v_nxt;
    e_w_r      <= e_w_nxt;
    out_data_r <= out_data_nxt;
    if (log_we) begin
      swap_a_r[logged_r] <= ba_r;
      swap_b_r[logged_r] <= bb_r;
    end
  end

  // cost memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (d_we) begin
      d_mem[d_waddr] <= d_wdata;
    end
    d_q <= d_mem[d_raddr];
  end

endmodule
`default_nettype wire

// ===== src/gbr_checker.sv =====
// port-level checks for the graph bisection refiner
`default_nettype none
module gbr_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire gbr_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire gbr_pkg::out_t out_data
);
  import gbr_pkg::*;

  // a run keeps the block busy on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.action == ACT_RUN |=> busy)
    else $error("run item did not make the block busy");

  // nothing follows the last result directly
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result after the last of a run");

  // results of a run come back to back in vertex order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid &&
      out_data.vertex_index == 5'($past(out_data.vertex_index) + 5'd1))
    else $error("results not consecutive");

  // one cut total for the whole run
  a_cut_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_data.cut_weight == $past(out_data.cut_weight))
    else $error("cut cost changed within a run");

endmodule

bind graph_bisection_refiner gbr_checker u_gbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/graph_bisection_refiner_tb.sv =====
// self-checking testbench for the graph bisection refiner
`default_nettype none
module graph_bisection_refiner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbr_pkg::*;

  // longest stretch with nothing accepted, sized for a full 32-vertex run
  // with 255 passes of 16 swaps each
  localparam int QUIET_LIMIT = 16000000;
  // settle time after the last result before touching the pass register
  localparam int SETTLE_CYCLES = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        in_data = '0;
  logic       out_valid;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  graph_bisection_refiner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // partition predictor: its own copy of graph, sides and pass limit
  // ---------------------------------------------------------------------
  logic [15:0] edge_wt [32][32];
  bit          part_of [32];
  int          vert_cnt = 0;
  logic [7:0]  pass_limit = MAX_PASSES_RST;
  longint      gain_d [32];
  bit [31:0]   locked;
  int          swap_a [17];
  int          swap_b [17];
  longint      swap_gain [17];

  out_t        expected_q [$];
  in_t         pending_q [$];
  int          fail_cnt = 0;

  initial begin
    for (int i = 0; i < 32; i++) begin
      part_of[i] = 1'b0;
      for (int j = 0; j < 32; j++) edge_wt[i][j] = '0;
    end
  end

  // cost correction after vertex s is (virtually) moved to the other side
  function automatic void shift_gains(int s);
    longint w;
    for (int v = 0; v < vert_cnt; v++) begin
      w = edge_wt[s][v];
      if (part_of[v] != part_of[s]) gain_d[v] -= 2 * w;
      else gain_d[v] += 2 * w;
    end
  endfunction

  // one kernighan-lin pass; returns 1 when a positive-gain prefix was applied
  function automatic bit refine_pass();
    int n, logged, ba, bb, bk;
    longint d, w, g, best, total, best_total;
    bit found;
    n = vert_cnt;
    logged = 0;
    for (int u = 0; u < n; u++) begin
      d = 0;
      for (int v = 0; v < n; v++) begin
        w = edge_wt[u][v];
        if (v == u) d -= 2 * w;
        else if (part_of[u] != part_of[v]) d += w;
        else d -= w;
      end
      gain_d[u] = d;
    end
    locked = '0;
    while (2 * logged < n && logged < 17) begin
      found = 1'b0;
      best = 0;
      ba = 0;
      bb = 0;
      // first strict maximum, a then b ascending
      for (int a = 0; a < n; a++) begin
        if (part_of[a] != 1'b0 || locked[a]) continue;
        for (int b = 0; b < n; b++) begin
          if (part_of[b] != 1'b1 || locked[b]) continue;
          g = gain_d[a] + gain_d[b] - 2 * longint'(edge_wt[a][b]);
          if (!found || g > best) begin
            found = 1'b1;
            best = g;
            ba = a;
            bb = b;
          end
        end
      end
      if (!found) break;
      locked[ba] = 1'b1;
      locked[bb] = 1'b1;
      shift_gains(ba);
      shift_gains(bb);
      swap_a[logged] = ba;
      swap_b[logged] = bb;
      swap_gain[logged] = best;
      logged++;
    end
    if (logged == 0) return 1'b0;
    total = 0;
    best_total = 0;
    bk = 0;
    for (int k = 0; k < logged; k++) begin
      total += swap_gain[k];
      if (k == 0 || total > best_total) begin
        best_total = total;
        bk = k;
      end
    end
    if (best_total <= 0) return 1'b0;
    for (int k = 0; k <= bk; k++) begin
      part_of[swap_a[k]] = 1'b1;
      part_of[swap_b[k]] = 1'b0;
    end
    return 1'b1;
  endfunction

  // update the graph model for one accepted item, queue any results
  function automatic void predict_item(in_t it);
    longint cut;
    out_t r;
    case (it.action)
      ACT_EDGE: begin
        edge_wt[it.vertex_u][it.vertex_v] = it.edge_cost;
        edge_wt[it.vertex_v][it.vertex_u] = it.edge_cost;
        if (int'(it.vertex_u) + 1 > vert_cnt) vert_cnt = int'(it.vertex_u) + 1;
        if (int'(it.vertex_v) + 1 > vert_cnt) vert_cnt = int'(it.vertex_v) + 1;
      end
      ACT_SIDE: part_of[it.vertex_u] = it.side_in;
      ACT_RUN: begin
        for (int p = 0; p < int'(pass_limit); p++)
          if (!refine_pass()) break;
        cut = 0;
        for (int u = 0; u < vert_cnt; u++)
          for (int v = u + 1; v < vert_cnt; v++)
            if (part_of[u] != part_of[v]) cut += edge_wt[u][v];
        if (cut > longint'(CUT_MAX)) cut = CUT_MAX;
        for (int i = 0; i < vert_cnt; i++) begin
          r.vertex_index = i[4:0];
          r.side_out = part_of[i];
          r.cut_weight = cut[CUT_BITS-1:0];
          r.last = (i + 1 == vert_cnt);
          expected_q = {expected_q, r};
        end
      end
      default: ;  // unused action: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // driver: items change on the falling edge, random gaps with bursts
  // ---------------------------------------------------------------------
  bit took = 1'b0;
  int gap_left = 0;
  bit burst = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold the item until the block takes it
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_q.size() > 0) begin
      in_data <= pending_q.pop_front();
      start <= 1'b1;
      gap_left <= burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) burst <= ~burst;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: accepts items and config writes, checks every result item
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    took <= start && !busy && rst_n;
    if (rst_n) begin
      if (cfg_we) pass_limit = cfg_wdata;
      if (start && !busy) predict_item(in_data);
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: vertex_index %0d", out_data.vertex_index);
          fail_cnt++;
        end else begin
          out_t e;
          e = expected_q.pop_front();
          if (out_data.vertex_index !== e.vertex_index) begin
            $error("vertex_index: expected %0d, actual %0d", e.vertex_index,
                   out_data.vertex_index);
            fail_cnt++;
          end
          if (out_data.side_out !== e.side_out) begin
            $error("side_out: expected %0d, actual %0d", e.side_out, out_data.side_out);
            fail_cnt++;
          end
          if (out_data.cut_weight !== e.cut_weight) begin
            $error("cut_weight: expected %0d, actual %0d", e.cut_weight,
                   out_data.cut_weight);
            fail_cnt++;
          end
          if (out_data.last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, out_data.last);
            fail_cnt++;
          end
        end
      end
    end
  end

  // watchdog: counts cycles in which nothing at all is accepted
  int quiet_cnt = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  function automatic void queue_item(action_t act, int u, int v, int c, bit s);
    in_t it;
    it.action = act;
    it.vertex_u = u[4:0];
    it.vertex_v = v[4:0];
    it.edge_cost = c[15:0];
    it.side_in = s;
    pending_q = {pending_q, it};
  endfunction

  // everything sent, every result item seen, block back to idle
  task automatic drain();
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_passes(logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one well-formed phase: random edges and sides within a vertex span,
  // an occasional unused action or run, and a run at the end
  task automatic random_phase(int span, int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        queue_item(ACT_EDGE, $urandom_range(0, span), $urandom_range(0, span),
                   $urandom_range(0, 65535), $urandom_range(0, 1));
      else if (r < 90)
        queue_item(ACT_SIDE, $urandom_range(0, span), $urandom_range(0, 31),
                   $urandom_range(0, 65535), $urandom_range(0, 1));
      else if (r < 95)
        queue_item(ACT_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 65535), $urandom_range(0, 1));
      else
        queue_item(ACT_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 65535), $urandom_range(0, 1));
    end
    queue_item(ACT_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 65535), $urandom_range(0, 1));
  endtask

  initial begin
    int pick;
    logic [7:0] pv;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (busy) @(posedge clk);  // adjacency clear sweep
    set_passes(8'd10);

    // directed: empty graph run, unused action, side set ahead of the count
    queue_item(ACT_RUN, 0, 0, 0, 1'b0);
    queue_item(ACT_NONE, 31, 31, 16'hFFFF, 1'b1);
    queue_item(ACT_SIDE, 5, 0, 0, 1'b1);
    // largest weight, then replaced; zero weight still grows the count
    queue_item(ACT_EDGE, 0, 1, 16'hFFFF, 1'b0);
    queue_item(ACT_EDGE, 1, 2, 0, 1'b0);
    queue_item(ACT_EDGE, 2, 2, 5, 1'b0);  // self loop
    queue_item(ACT_EDGE, 0, 1, 7, 1'b0);
    queue_item(ACT_EDGE, 3, 4, 300, 1'b0);
    queue_item(ACT_EDGE, 5, 0, 900, 1'b0);  // pulls vertex 5 into the graph
    queue_item(ACT_SIDE, 1, 0, 0, 1'b1);
    queue_item(ACT_SIDE, 3, 0, 0, 1'b1);
    queue_item(ACT_RUN, 0, 0, 0, 1'b0);
    drain();
    set_passes(8'd0);  // no passes: just report the cut
    queue_item(ACT_SIDE, 0, 0, 0, 1'b1);
    queue_item(ACT_RUN, 0, 0, 0, 1'b0);
    drain();
    set_passes(8'd1);
    queue_item(ACT_EDGE, 2, 4, 16'h8000, 1'b0);
    queue_item(ACT_RUN, 0, 0, 0, 1'b0);
    drain();
    set_passes(8'd255);
    queue_item(ACT_SIDE, 2, 0, 0, 1'b1);
    queue_item(ACT_RUN, 0, 0, 0, 1'b0);
    drain();

    // random phases on a small graph keep runs short
    for (int ph = 0; ph < 12; ph++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: pv = 8'd0;
        1: pv = 8'd1;
        2: pv = 8'd255;
        3: pv = 8'd10;
        default: pv = $urandom_range(2, 6);
      endcase
      set_passes(pv);
      random_phase($urandom_range(3, 11), $urandom_range(12, 20));
      drain();
    end

    // full-size graph last, since the vertex count never shrinks
    set_passes(8'd255);
    queue_item(ACT_EDGE, 31, 30, 16'hFFFF, 1'b0);
    queue_item(ACT_SIDE, 31, 0, 0, 1'b1);
    random_phase(31, 16);
    drain();
    set_passes(8'd10);
    random_phase(31, 10);
    drain();

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
